@@ src/rp3d_pkg.sv @@
package rp3d_pkg;

	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int COORD_W = 16;
	localparam int ANGLE_W = 16;
	localparam int OUT_W = 19;
	localparam int TRIG_W = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ASPECT_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ASPECT_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 2'd2;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic [15:0] SIN_A = 16'd51472;
	localparam logic [15:0] SIN_B = 16'd21024;
	localparam logic [15:0] SIN_C = 16'd2320;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sd262143;
	localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sd262143 - 19'sd1;

	typedef logic signed [TRIG_W-1:0] trig_t;

endpackage

@@ src/rp3d_if.sv @@
interface rp3d_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic signed [15:0] point_z;
	logic [15:0] angle_a;
	logic [15:0] angle_b;
	logic [15:0] angle_c;
	modport source (output valid, point_x, point_y, point_z, angle_a, angle_b, angle_c,
		input ready);
	modport sink (input valid, point_x, point_y, point_z, angle_a, angle_b, angle_c,
		output ready);
	modport monitor (input valid, ready, point_x, point_y, point_z, angle_a, angle_b,
		angle_c);
endinterface

interface rp3d_out_if;
	logic valid;
	logic ready;
	logic signed [18:0] left_out;
	logic signed [18:0] right_out;
	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
	modport monitor (input valid, ready, left_out, right_out);
endinterface

@@ src/rp3d_sine.sv @@
// four-stage quarter-wave polynomial sine, result q15 signed
module rp3d_sine #(
	parameter int SINE_TABLE_BITS = rp3d_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic            clk,
	input  logic [3:0]      en,
	input  logic [15:0]     phase,
	output rp3d_pkg::trig_t sine_s4
);
	localparam int SH = 16 - SINE_TABLE_BITS;
	logic [15:0] p;
	logic [13:0] r;
	logic [14:0] t;
	logic [29:0] tt;
	logic [31:0] u_full;
	logic [15:0] v;
	logic [31:0] w_full;
	logic [15:0] x;
	logic [31:0] s_full;
	logic [15:0] s;
	logic [15:0] t2_s1, t2_s2, v_s2, x_s3;
	logic [14:0] t_s1, t_s2, t_s3;
	logic neg_s1, neg_s2, neg_s3;

	always_comb begin
		p = (phase >> SH) << SH;
		r = p[13:0];
		t = p[14] ? (15'd16384 - {1'b0, r}) : {1'b0, r};
		tt = t * t;
		u_full = rp3d_pkg::SIN_C * t2_s1;
		v = rp3d_pkg::SIN_B - u_full[29:14];
		w_full = v_s2 * t2_s2;
		x = rp3d_pkg::SIN_A - w_full[29:14];
		s_full = x_s3 * {1'b0, t_s3};
		s = s_full[29:14];
	end

	// one multiply per stage
	always_ff @(posedge clk) begin
		if (en[0]) begin
			t2_s1 <= tt[29:14];
			t_s1 <= t;
			neg_s1 <= p[15];
		end
		if (en[1]) begin
			v_s2 <= v;
			t2_s2 <= t2_s1;
			t_s2 <= t_s1;
			neg_s2 <= neg_s1;
		end
		if (en[2]) begin
			x_s3 <= x;
			t_s3 <= t_s2;
			neg_s3 <= neg_s2;
		end
		if (en[3]) begin
			sine_s4 <= neg_s3 ? -rp3d_pkg::trig_t'({1'b0, s}) : rp3d_pkg::trig_t'({1'b0, s});
		end
	end
endmodule

@@ src/rp3d_rot.sv @@
// one registered plane rotation: (u*c - v*s, u*s + v*c) >> 15, round half up
module rp3d_rot #(
	parameter int IN_W = 18,
	parameter int OUT_W = 18
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [IN_W-1:0]  u,
	input  logic signed [IN_W-1:0]  v,
	input  rp3d_pkg::trig_t         c,
	input  rp3d_pkg::trig_t         s,
	output logic signed [OUT_W-1:0] a_q,
	output logic signed [OUT_W-1:0] b_q
);
	localparam int PW = IN_W + rp3d_pkg::TRIG_W + 1;
	logic signed [PW-1:0] ea, eb;

	always_comb begin
		ea = PW'(u * c) - PW'(v * s) + PW'(16384);
		eb = PW'(u * s) + PW'(v * c) + PW'(16384);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_q <= OUT_W'(ea >>> 15);
			b_q <= OUT_W'(eb >>> 15);
		end
	end
endmodule

@@ src/rotate_project_3d_point_unit.sv @@
// rotate_project_3d_point_unit
// rotates a q3.13 point by three phase angles (xy by a, xz by b, xy by c) and
// projects it with perspective to a saturated q6.13 left/right pair.
// channels: in_ch (sink) takes one point and three angles per item, out_ch
// (source) gives one left/right item per input item, in order.
// configuration: cfg_we/cfg_idx/cfg_data write aspect_x (0), aspect_y (1),
// depth_amount (2); other indexes are ignored. write only while idle.
// throughput: one item per cycle sustained while out_ch.ready stays high, in
// a ten-stage pipeline of four sine polynomial stages, three rotations,
// depth factor, projection product and final sum.
// stalls: a full stage holds only while all later stages are full and
// out_ch.ready is low; in_ch.ready stays high while any stage is empty.
// reset: arst_n clears all valid bits and the configuration registers to
// zero; the data registers are not reset.
module rotate_project_3d_point_unit #(
	parameter int SINE_TABLE_BITS = rp3d_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	rp3d_in_if.sink     in_ch,
	rp3d_out_if.source  out_ch
);
	localparam int NS = 10;
	logic signed [15:0] aspect_x_q, aspect_y_q;
	logic [15:0] depth_q;
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aspect_x_q <= '0;
			aspect_y_q <= '0;
			depth_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rp3d_pkg::REG_ASPECT_X: aspect_x_q <= cfg_data;
				rp3d_pkg::REG_ASPECT_Y: aspect_y_q <= cfg_data;
				rp3d_pkg::REG_DEPTH: depth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage i loads when it is empty or the next stage moves
	always_comb begin
		en[NS-1] = !vld_q[NS-1] || out_ch.ready;
		for (int i = NS - 2; i >= 0; i--) en[i] = !vld_q[i] || en[i+1];
	end
	assign in_ch.ready = en[0];
	assign out_ch.valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else begin
			for (int i = NS - 1; i > 0; i--) if (en[i]) vld_q[i] <= vld_q[i-1];
			if (en[0]) vld_q[0] <= in_ch.valid;
		end
	end

	// stages 1 to 4: sines and cosines
	rp3d_pkg::trig_t sa_s4, ca_s4, sb_s4, cb_s4, sc_s4, cc_s4;
	rp3d_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sa (.clk(clk), .en(en[3:0]),
		.phase(in_ch.angle_a), .sine_s4(sa_s4));
	rp3d_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_ca (.clk(clk), .en(en[3:0]),
		.phase(in_ch.angle_a + 16'd16384), .sine_s4(ca_s4));
	rp3d_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sb (.clk(clk), .en(en[3:0]),
		.phase(in_ch.angle_b), .sine_s4(sb_s4));
	rp3d_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_cb (.clk(clk), .en(en[3:0]),
		.phase(in_ch.angle_b + 16'd16384), .sine_s4(cb_s4));
	rp3d_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sc (.clk(clk), .en(en[3:0]),
		.phase(in_ch.angle_c), .sine_s4(sc_s4));
	rp3d_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_cc (.clk(clk), .en(en[3:0]),
		.phase(in_ch.angle_c + 16'd16384), .sine_s4(cc_s4));

	// point travels beside the sine stages as {x, y, z}
	logic [47:0] pt_s1, pt_s2, pt_s3, pt_s4;
	logic signed [15:0] px_s4, py_s4, pz_s4, pz_s5;
	rp3d_pkg::trig_t sb_s5, cb_s5, sc_s5, cc_s5, sc_s6, cc_s6;
	assign {px_s4, py_s4, pz_s4} = pt_s4;

	always_ff @(posedge clk) begin
		if (en[0]) pt_s1 <= {in_ch.point_x, in_ch.point_y, in_ch.point_z};
		if (en[1]) pt_s2 <= pt_s1;
		if (en[2]) pt_s3 <= pt_s2;
		if (en[3]) pt_s4 <= pt_s3;
		if (en[4]) begin
			sb_s5 <= sb_s4; cb_s5 <= cb_s4; sc_s5 <= sc_s4; cc_s5 <= cc_s4; pz_s5 <= pz_s4;
		end
		if (en[5]) begin
			sc_s6 <= sc_s5; cc_s6 <= cc_s5;
		end
	end

	// stage 5: rotate xy by a
	logic signed [17:0] x1_s5, y1_s5, y1_s6;
	rp3d_rot #(.IN_W(16), .OUT_W(18)) u_rot_a (.clk(clk), .en(en[4]), .u(px_s4), .v(py_s4),
		.c(ca_s4), .s(sa_s4), .a_q(x1_s5), .b_q(y1_s5));

	// stage 6: rotate xz by b
	logic signed [18:0] x2_s6, z2_s6;
	rp3d_rot #(.IN_W(18), .OUT_W(19)) u_rot_b (.clk(clk), .en(en[5]), .u(x1_s5),
		.v(18'(pz_s5)), .c(cb_s5), .s(sb_s5), .a_q(x2_s6), .b_q(z2_s6));

	logic signed [18:0] z2_s7;
	always_ff @(posedge clk) begin
		if (en[5]) y1_s6 <= y1_s5;
		if (en[6]) z2_s7 <= z2_s6;
	end

	// stage 7: rotate xy by c
	logic signed [19:0] x3_s7, y3_s7;
	rp3d_rot #(.IN_W(19), .OUT_W(20)) u_rot_c (.clk(clk), .en(en[6]), .u(x2_s6),
		.v(19'(y1_s6)), .c(cc_s6), .s(sc_s6), .a_q(x3_s7), .b_q(y3_s7));

	// stage 8: depth factor, offset term, x difference and y sum
	logic signed [37:0] fp, op;
	logic signed [20:0] f_s8, off_s8;
	logic signed [20:0] dx_s8, dy_s8;
	logic signed [19:0] x3_s8, y3_s8;
	always_comb begin
		fp = 38'(signed'({1'b0, depth_q})) * 38'(z2_s7 + 19'sd8192) + 38'sd32768;
		op = 38'(aspect_x_q) * 38'(signed'({1'b0, depth_q})) + 38'sd32768;
	end
	always_ff @(posedge clk) begin
		if (en[7]) begin
			f_s8 <= 21'(fp >>> 16);
			off_s8 <= 21'(op >>> 16);
			dx_s8 <= 21'(x3_s7) - 21'(aspect_x_q);
			dy_s8 <= 21'(y3_s7) + 21'(aspect_y_q);
			x3_s8 <= x3_s7;
			y3_s8 <= y3_s7;
		end
	end

	// stage 9: projection products
	logic signed [41:0] lp, rp;
	logic signed [28:0] lt_s9, rt_s9;
	logic signed [20:0] off_s9;
	logic signed [19:0] x3_s9, y3_s9;
	always_comb begin
		lp = 42'(f_s8) * 42'(dx_s8) + 42'sd4096;
		rp = 42'(f_s8) * 42'(dy_s8) + 42'sd4096;
	end
	always_ff @(posedge clk) begin
		if (en[8]) begin
			lt_s9 <= 29'(lp >>> 13);
			rt_s9 <= 29'(rp >>> 13);
			off_s9 <= off_s8;
			x3_s9 <= x3_s8;
			y3_s9 <= y3_s8;
		end
	end

	// stage 10: sums and saturation
	logic signed [30:0] ls, rs;
	logic signed [18:0] left_s10, right_s10;
	always_comb begin
		ls = 31'(x3_s9) - 31'(lt_s9) - 31'(off_s9);
		rs = 31'(y3_s9) - 31'(rt_s9) + 31'(off_s9);
	end
	always_ff @(posedge clk) begin
		if (en[9]) begin
			if (ls > 31'(rp3d_pkg::OUT_MAX)) left_s10 <= rp3d_pkg::OUT_MAX;
			else if (ls < 31'(rp3d_pkg::OUT_MIN)) left_s10 <= rp3d_pkg::OUT_MIN;
			else left_s10 <= 19'(ls);
			if (rs > 31'(rp3d_pkg::OUT_MAX)) right_s10 <= rp3d_pkg::OUT_MAX;
			else if (rs < 31'(rp3d_pkg::OUT_MIN)) right_s10 <= rp3d_pkg::OUT_MIN;
			else right_s10 <= 19'(rs);
		end
	end
	assign out_ch.left_out = left_s10;
	assign out_ch.right_out = right_s10;
endmodule
